// ----- rtl/stable_priority_queue_core_assert.svh -----
// Assertion macros shared by the queue RTL; clocked on clk, disabled while rst_n is low.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// Shared constants, types and address helper for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int ENTRY_W = PRIO_W + TAG_W;

    localparam int S_TDATA_W = ((PRIO_W + TAG_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TAG_W + PRIO_W + OCC_W + 7) / 8) * 8;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    // Logical slot j behind the head maps onto the circular store.
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] j);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, j};
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/spq_ram.sv -----
// Generic one-write one-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/spq_seq.sv -----
// Sequencer: insertion walk with the shared priority compare, head-pointer pop.
`timescale 1ns / 1ps
`include "stable_priority_queue_core_assert.svh"

module spq_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  spq_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_ready,
    output spq_pkg::res_t res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [spq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [spq_pkg::IDX_W-1:0]    base_reg, base_next;
    logic [spq_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [spq_pkg::STAT_W-1:0]   status_reg, status_next;
    logic [spq_pkg::PRIO_W-1:0]   prio_reg, prio_next;
    logic [spq_pkg::TAG_W-1:0]    tag_reg, tag_next;

    logic                         wr_en, rd_en;
    logic [spq_pkg::IDX_W-1:0]    wr_j, rd_j, wr_addr, rd_addr;
    logic [spq_pkg::ENTRY_W-1:0]  wr_data, rd_data;
    logic [spq_pkg::CNT_W-1:0]    count_after;
    logic signed [spq_pkg::PRIO_W-1:0] rd_prio, new_prio;
    logic                         shift_up;

    spq_ram #(
        .DATA_W (spq_pkg::ENTRY_W),
        .DEPTH  (spq_pkg::QUEUE_DEPTH),
        .ADDR_W (spq_pkg::IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_addr  = spq_pkg::phys_addr(base_reg, wr_j);
    assign rd_addr  = spq_pkg::phys_addr(base_reg, rd_j);
    assign rd_prio  = $signed(rd_data[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W]);
    assign new_prio = $signed(prio_reg);
    // shared compare: stored entry strictly lower moves back one slot
    assign shift_up = rd_prio < new_prio;

    always_comb
    begin
        case (status_reg)
            spq_pkg::ST_PUSHED: count_after = count_reg + 1'b1;
            spq_pkg::ST_POPPED: count_after = count_reg - 1'b1;
            default:            count_after = count_reg;
        endcase
    end

    always_comb
    begin
        res.status    = status_reg;
        res.occupancy = spq_pkg::OCC_W'(count_after);
        if (status_reg == spq_pkg::ST_POPPED)
        begin
            res.tag  = rd_data[spq_pkg::TAG_W-1:0];
            res.prio = rd_data[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W];
        end
        else
        begin
            res.tag  = '0;
            res.prio = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        base_next   = base_reg;
        i_next      = i_reg;
        status_next = status_reg;
        prio_next   = prio_reg;
        tag_next    = tag_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_j        = i_reg;
        rd_j        = '0;
        wr_data     = {prio_reg, tag_reg};
        op_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    prio_next = op.prio;
                    tag_next  = op.tag;
                    if (op.func == spq_pkg::FUNC_PUSH)
                    begin
                        if (count_reg >= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
                        begin
                            status_next = spq_pkg::ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            status_next = spq_pkg::ST_PUSHED;
                            i_next      = spq_pkg::IDX_W'(count_reg);
                            if (count_reg == '0)
                            begin
                                state_next = S_INS;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_j       = spq_pkg::IDX_W'(count_reg - 1'b1);
                                state_next = S_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            status_next = spq_pkg::ST_POPPED;
                            rd_en       = 1'b1;   // head slot
                        end
                        state_next = S_OUT;
                    end
                end
            end

            S_CMP:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    wr_data = rd_data;
                    i_next  = i_reg - 1'b1;
                    if (i_reg == spq_pkg::IDX_W'(1))
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_j  = i_reg - spq_pkg::IDX_W'(2);
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_INS:
            begin
                wr_en      = 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                res_valid = 1'b1;
                wr_j      = spq_pkg::IDX_W'(1);   // adder reused for head advance
                if (res_ready)
                begin
                    count_next = count_after;
                    if (status_reg == spq_pkg::ST_POPPED)
                    begin
                        base_next = wr_addr;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        status_reg <= status_next;
        prio_reg   <= prio_next;
        tag_reg    <= tag_next;
    end

    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH), "count above depth")
    `SPQ_ASSERT_ALWAYS(a_base_bound, base_reg < spq_pkg::IDX_W'(spq_pkg::QUEUE_DEPTH - 1) || base_reg == spq_pkg::IDX_W'(spq_pkg::QUEUE_DEPTH - 1), "head pointer out of range")
    `SPQ_ASSERT_ALWAYS(a_cmp_slot, state_reg != S_CMP || i_reg != '0, "compare walk at slot zero")
    `SPQ_ASSERT_NEXT(a_pop_count, res_valid && res_ready && status_reg == spq_pkg::ST_POPPED, count_reg == spq_pkg::CNT_W'($past(count_reg) - 1'b1), "pop did not decrement count")

endmodule

// ----- rtl/stable_priority_queue_core.sv -----
// Top level of the stable max-priority queue: stream ports and result register.
`timescale 1ns / 1ps

//  channel  | direction | tdata (low bit up)               | tuser
//  ---------+-----------+----------------------------------+---------------
//  s_*      | in        | prio_in[15:0], tag_in[31:16]     | func[0]
//  m_*      | out       | tag_out[15:0], prio_out[31:16],  | status[1:0]
//           |           | occupancy[36:32], zero pad       |
//
// One operation at a time; s_tready is high only while the sequencer idles.
// Rejected push or any pop: idle, then the output state, where the result register loads.
// Push: idle, then a walk over the lower-priority entries from the tail at one RAM read
// and one write per cycle, then the new entry is written and the result register loads.
// Reset empties the queue at once (count and head pointer); RAM contents stay.
// m_tready low holds the result register and stalls the next operation's completion.

module stable_priority_queue_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,   // prio_in, tag_in
    input  logic [0:0]                    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,   // tag_out, prio_out, occupancy
    output logic [spq_pkg::STAT_W-1:0]    m_tuser    // status
);

    spq_pkg::op_t  op;
    spq_pkg::res_t res;
    logic          res_valid, res_ready;

    logic                          m_tvalid_reg;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [spq_pkg::STAT_W-1:0]    m_tuser_reg;

    assign op.func = s_tuser[0];
    assign op.prio = s_tdata[spq_pkg::PRIO_W-1:0];
    assign op.tag  = s_tdata[spq_pkg::PRIO_W+spq_pkg::TAG_W-1:spq_pkg::PRIO_W];

    spq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (s_tvalid),
        .op_ready  (s_tready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register is free when empty or drained this cycle
    assign res_ready    = !m_tvalid_reg || m_tready;
    assign m_tdata_next = spq_pkg::M_TDATA_W'({res.occupancy, res.prio, res.tag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
